FILE: sv/teag_pkg.sv
// Shared types, constants and helper functions for the tiered event admission gate.
package teag_pkg;

  localparam int CATEGORIES = 64;
  localparam int TIME_BITS  = 32;

  localparam int CAT_IN_W = 6;
  localparam int CAT_W    = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int REJ_W    = 15;
  localparam int GAP_W    = 31;
  localparam int ENTRY_W  = TIME_BITS + REJ_W;
  localparam int SUM_W    = ((TIME_BITS > GAP_W) ? TIME_BITS : GAP_W) + 1;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W   = $clog2(NUM_REGS * 4);
  localparam int IDX_W    = $clog2(NUM_REGS);

  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_FIRE   = 2'd1,
    OP_MUTE   = 2'd2,
    OP_REJECT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    TIER_SILENT  = 2'd0,
    TIER_AMBIENT = 2'd1,
    TIER_ACTIVE  = 2'd2,
    TIER_URGENT  = 2'd3
  } tier_e;

  typedef enum logic [2:0] {
    OUT_PASS   = 3'd0,
    OUT_RATE   = 3'd1,
    OUT_QUIET  = 3'd2,
    OUT_MUTED  = 3'd3,
    OUT_SILENT = 3'd4
  } outcome_e;

  typedef enum logic [IDX_W-1:0] {
    REG_QUIET_EN   = 3'd0,
    REG_QUIET_ST   = 3'd1,
    REG_QUIET_END  = 3'd2,
    REG_GAP_AMB    = 3'd3,
    REG_GAP_ACT    = 3'd4,
    REG_GAP_URG    = 3'd5,
    REG_REJ_LIMIT  = 3'd6,
    REG_AUTO_MUTE  = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic               quiet_enable;
    logic [4:0]         quiet_start;
    logic [4:0]         quiet_end;
    logic [GAP_W-1:0]   gap_ambient;
    logic [GAP_W-1:0]   gap_active;
    logic [GAP_W-1:0]   gap_urgent;
    logic signed [15:0] reject_limit;
    logic signed [31:0] auto_mute_secs;
  } cfg_t;

  typedef struct packed {
    op_e                   op;
    tier_e                 tier;
    logic [CAT_IN_W-1:0]   category;
    logic [TIME_BITS-1:0]  now;
    logic [4:0]            hour;
    logic signed [31:0]    mute_secs;
    logic signed [15:0]    reject_in;
  } item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] mute_until;
    logic [REJ_W-1:0]     rejects;
  } entry_t;

  typedef struct packed {
    logic                 ent_we;
    entry_t               ent_new;
    logic                 tlf_we;
    outcome_e             outcome;
    logic [REJ_W-1:0]     reject_count;
    logic [TIME_BITS-1:0] last_fired;
  } upd_t;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  function automatic logic cat_in_range(input logic [CAT_IN_W-1:0] cat);
    return 32'(cat) < 32'(CATEGORIES);
  endfunction

  // Expiry for a mute of dur seconds from now: clear on dur <= 0, saturate on overflow.
  function automatic logic [TIME_BITS-1:0] mute_expiry(input logic [TIME_BITS-1:0] now,
                                                       input logic signed [31:0] dur);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(now) + SUM_W'(dur[30:0]);
    if (dur <= 32'sd0) begin
      return '0;
    end
    if (sum > SUM_W'(TIME_MAX)) begin
      return TIME_MAX;
    end
    return TIME_BITS'(sum);
  endfunction

endpackage

FILE: sv/tiered_event_admission_gate_core.sv
// Top level of the tiered event admission gate: input stage, category store, result register.
// An accepted item passes the input register, then the result register, which drives out_valid;
// the result is valid while out_valid is high. Results cannot be stalled by the receiver.
// Throughput: one item per cycle; busy stays low, the category store is read at accept
// and written in the following cycle, with a bypass for back-to-back items on one category.
// Reset: synchronous rst_n restores register defaults, clears firing times and entry marks.
module tiered_event_admission_gate_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [1:0]                  in_tier,
  input  logic [5:0]                  in_category,
  input  logic [31:0]                 in_now_secs,
  input  logic [4:0]                  in_local_hour,
  input  logic signed [31:0]          in_mute_secs,
  input  logic signed [15:0]          in_reject_in,
  output logic                        out_valid,
  output logic [2:0]                  out_outcome,
  output logic [14:0]                 out_reject_count,
  output logic [31:0]                 out_last_fired,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [teag_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import teag_pkg::*;

  cfg_t                 cfg;
  logic                 accept;
  item_t                s1_item_r;
  logic                 s1_vld_r;
  logic [CAT_W-1:0]     cat_idx;
  logic                 cat_ok;
  logic [CATEGORIES-1:0] ent_vld_r;
  logic                 byp_vld_r;
  logic [CAT_W-1:0]     byp_addr_r;
  entry_t               byp_data_r;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               ram_q;
  entry_t               ent_cur;
  logic                 ent_wr;
  logic [TIME_BITS-1:0] tlf_r [3];
  logic [TIME_BITS-1:0] last_cur;
  upd_t                 upd;
  logic                 out_valid_r;
  logic [2:0]           out_outcome_r;
  logic [14:0]          out_reject_r;
  logic [31:0]          out_last_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  teag_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.op        <= op_e'(in_op);
      s1_item_r.tier      <= tier_e'(in_tier);
      s1_item_r.category  <= in_category;
      s1_item_r.now       <= TIME_BITS'(in_now_secs);
      s1_item_r.hour      <= in_local_hour;
      s1_item_r.mute_secs <= in_mute_secs;
      s1_item_r.reject_in <= in_reject_in;
    end
  end

  assign cat_idx = CAT_W'(s1_item_r.category);
  assign cat_ok  = cat_in_range(s1_item_r.category);
  assign ent_wr  = s1_vld_r && upd.ent_we;

  teag_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CATEGORIES)
  ) u_store (
    .clk   (clk),
    .we    (ent_wr),
    .waddr (cat_idx),
    .wdata (upd.ent_new),
    .raddr (CAT_W'(in_category)),
    .rdata (ram_rdata)
  );

  assign ram_q = entry_t'(ram_rdata);

  // Hold the write made at the read edge; the RAM returns the old word for it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_vld_r <= 1'b0;
    end else begin
      byp_vld_r <= ent_wr;
    end
  end

  always_ff @(posedge clk) begin
    byp_addr_r <= cat_idx;
    byp_data_r <= upd.ent_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (ent_wr) begin
      ent_vld_r[cat_idx] <= 1'b1;
    end
  end

  always_comb begin
    priority if (!cat_ok) begin
      ent_cur = '0;
    end else if (byp_vld_r && byp_addr_r == cat_idx) begin
      ent_cur = byp_data_r;
    end else if (ent_vld_r[cat_idx]) begin
      ent_cur = ram_q;
    end else begin
      ent_cur = '0;
    end
  end

  always_comb begin
    unique case (s1_item_r.tier)
      TIER_AMBIENT: last_cur = tlf_r[0];
      TIER_ACTIVE:  last_cur = tlf_r[1];
      TIER_URGENT:  last_cur = tlf_r[2];
      default:      last_cur = '0;
    endcase
  end

  teag_eval u_eval (
    .item (s1_item_r),
    .cfg  (cfg),
    .ent  (ent_cur),
    .last (last_cur),
    .upd  (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlf_r[0] <= '0;
      tlf_r[1] <= '0;
      tlf_r[2] <= '0;
    end else if (s1_vld_r && upd.tlf_we) begin
      unique case (s1_item_r.tier)
        TIER_AMBIENT: tlf_r[0] <= s1_item_r.now;
        TIER_ACTIVE:  tlf_r[1] <= s1_item_r.now;
        TIER_URGENT:  tlf_r[2] <= s1_item_r.now;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      out_outcome_r <= upd.outcome;
      out_reject_r  <= upd.reject_count;
      out_last_r    <= 32'(upd.last_fired);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_reject_count = out_reject_r;
  assign out_last_fired   = out_last_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("accepted item produced no result");

  a_outcome_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome != OUT_PASS) |-> $past(s1_item_r.op) == OP_CHECK)
    else $error("non-check item gave a non-pass outcome");

  a_silent_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome == OUT_SILENT) |-> out_last_fired == '0)
    else $error("silent item reported a firing time");

  a_entry_marked: assert property (@(posedge clk) disable iff (!rst_n)
    ent_wr |=> ent_vld_r[$past(cat_idx)])
    else $error("written category entry not marked valid");

endmodule

FILE: sv/teag_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module teag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/teag_cfg_regs.sv
// APB-style configuration register bank for the admission gate.
module teag_cfg_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [teag_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output teag_pkg::cfg_t         cfg
);
  import teag_pkg::*;

  cfg_t     cfg_r;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quiet_enable   <= 1'b1;
      cfg_r.quiet_start    <= 5'd22;
      cfg_r.quiet_end      <= 5'd7;
      cfg_r.gap_ambient    <= GAP_W'(1800);
      cfg_r.gap_active     <= GAP_W'(300);
      cfg_r.gap_urgent     <= '0;
      cfg_r.reject_limit   <= 16'sd3;
      cfg_r.auto_mute_secs <= 32'sd86400;
    end else if (wr_en) begin
      unique case (idx)
        REG_QUIET_EN:  cfg_r.quiet_enable   <= pwdata[0];
        REG_QUIET_ST:  cfg_r.quiet_start    <= pwdata[4:0];
        REG_QUIET_END: cfg_r.quiet_end      <= pwdata[4:0];
        REG_GAP_AMB:   cfg_r.gap_ambient    <= pwdata[GAP_W-1:0];
        REG_GAP_ACT:   cfg_r.gap_active     <= pwdata[GAP_W-1:0];
        REG_GAP_URG:   cfg_r.gap_urgent     <= pwdata[GAP_W-1:0];
        REG_REJ_LIMIT: cfg_r.reject_limit   <= pwdata[15:0];
        REG_AUTO_MUTE: cfg_r.auto_mute_secs <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_QUIET_EN:  prdata = 32'(cfg_r.quiet_enable);
      REG_QUIET_ST:  prdata = 32'(cfg_r.quiet_start);
      REG_QUIET_END: prdata = 32'(cfg_r.quiet_end);
      REG_GAP_AMB:   prdata = 32'(cfg_r.gap_ambient);
      REG_GAP_ACT:   prdata = 32'(cfg_r.gap_active);
      REG_GAP_URG:   prdata = 32'(cfg_r.gap_urgent);
      REG_REJ_LIMIT: prdata = 32'(cfg_r.reject_limit);
      REG_AUTO_MUTE: prdata = cfg_r.auto_mute_secs;
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: sv/teag_eval.sv
// Outcome decision and state update for one item held in the input register.
module teag_eval (
  input  teag_pkg::item_t                 item,
  input  teag_pkg::cfg_t                  cfg,
  input  teag_pkg::entry_t                ent,
  input  logic [teag_pkg::TIME_BITS-1:0]  last,
  output teag_pkg::upd_t                  upd
);
  import teag_pkg::*;

  logic             cat_ok;
  logic             quiet;
  logic             non_urgent;
  logic [GAP_W-1:0] need;
  logic [SUM_W-1:0] elapsed;
  logic             rate_hit;
  logic             auto_mute;
  entry_t           ent_new;

  assign cat_ok     = cat_in_range(item.category);
  assign non_urgent = (item.tier != TIER_URGENT);

  always_comb begin
    if (!cfg.quiet_enable || cfg.quiet_start == cfg.quiet_end) begin
      quiet = 1'b0;
    end else if (cfg.quiet_start < cfg.quiet_end) begin
      quiet = (item.hour >= cfg.quiet_start) && (item.hour < cfg.quiet_end);
    end else begin
      // window wraps past midnight
      quiet = (item.hour >= cfg.quiet_start) || (item.hour < cfg.quiet_end);
    end
  end

  always_comb begin
    unique case (item.tier)
      TIER_AMBIENT: need = cfg.gap_ambient;
      TIER_ACTIVE:  need = cfg.gap_active;
      TIER_URGENT:  need = cfg.gap_urgent;
      default:      need = '0;
    endcase
  end

  assign elapsed  = SUM_W'(item.now) - SUM_W'(last);
  assign rate_hit = (need != '0) && (last != '0) &&
                    ((item.now < last) || (elapsed < SUM_W'(need)));

  assign auto_mute = (item.reject_in >= cfg.reject_limit);

  always_comb begin
    ent_new = ent;
    unique case (item.op)
      OP_MUTE: begin
        ent_new.mute_until = mute_expiry(item.now, item.mute_secs);
      end
      OP_REJECT: begin
        ent_new.rejects = (item.reject_in <= 16'sd0) ? '0 : item.reject_in[REJ_W-1:0];
        if (auto_mute) begin
          ent_new.mute_until = mute_expiry(item.now, cfg.auto_mute_secs);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    upd.ent_we  = cat_ok && (item.op == OP_MUTE || item.op == OP_REJECT);
    upd.ent_new = ent_new;
    upd.tlf_we  = (item.op == OP_FIRE) && (item.tier != TIER_SILENT);
    upd.outcome = OUT_PASS;
    if (item.op == OP_CHECK) begin
      priority if (item.tier == TIER_SILENT) begin
        upd.outcome = OUT_SILENT;
      end else if (non_urgent && item.now < ent.mute_until) begin
        upd.outcome = OUT_MUTED;
      end else if (non_urgent && quiet) begin
        upd.outcome = OUT_QUIET;
      end else if (rate_hit) begin
        upd.outcome = OUT_RATE;
      end else begin
        upd.outcome = OUT_PASS;
      end
    end
    upd.reject_count = cat_ok ? ent_new.rejects : '0;
    if (item.tier == TIER_SILENT) begin
      upd.last_fired = '0;
    end else if (upd.tlf_we) begin
      upd.last_fired = item.now;
    end else begin
      upd.last_fired = last;
    end
  end

endmodule

FILE: tb/sv/teag_admission_checker.sv
// Checker for the tiered event admission gate: mirrors gate state, predicts and compares results.
module teag_admission_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [1:0]                  in_tier,
  input  logic [5:0]                  in_category,
  input  logic [31:0]                 in_now_secs,
  input  logic [4:0]                  in_local_hour,
  input  logic signed [31:0]          in_mute_secs,
  input  logic signed [15:0]          in_reject_in,
  input  logic                        out_valid,
  input  logic [2:0]                  out_outcome,
  input  logic [14:0]                 out_reject_count,
  input  logic [31:0]                 out_last_fired,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [teag_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          mismatches,
  output int                          awaiting,
  output int                          compared
);
  timeunit 1ns;
  timeprecision 1ps;
  import teag_pkg::*;

  typedef struct packed {
    outcome_e         outcome;
    logic [REJ_W-1:0] rejects;
    logic [31:0]      last_fired;
  } verdict_t;

  // Register copy
  logic               quiet_on;
  logic [4:0]         quiet_from;
  logic [4:0]         quiet_to;
  logic [GAP_W-1:0]   min_gap [1:3];
  logic signed [15:0] auto_mute_at;
  logic signed [31:0] auto_mute_len;

  // Gate state copy
  logic [31:0]      fired_at [1:3];
  logic [31:0]      muted_until [CATEGORIES];
  logic [REJ_W-1:0] rejects_held [CATEGORIES];

  verdict_t awaited_q [$];
  int       fails = 0;
  int       done = 0;

  assign mismatches = fails;
  assign compared   = done;

  // Expiry for a mute of dur seconds: clear when dur is not positive, saturate on overflow.
  function automatic logic [31:0] expiry_after(input logic [31:0] now,
                                               input logic signed [31:0] dur);
    logic [32:0] sum;
    sum = {1'b0, now} + {2'b00, dur[30:0]};
    if (dur <= 0) return '0;
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic logic hour_is_quiet(input logic [4:0] h);
    if (!quiet_on || quiet_from == quiet_to) return 1'b0;
    if (quiet_from < quiet_to) return h >= quiet_from && h < quiet_to;
    return h >= quiet_from || h < quiet_to;
  endfunction

  // Apply one item to the state copy and return the result it should produce.
  // A 6-bit category always has storage with 64 categories.
  function automatic verdict_t admit(input item_t it);
    verdict_t         v;
    logic [31:0]      last;
    logic [GAP_W-1:0] need;
    int unsigned      c;
    c = it.category;
    v.outcome = OUT_PASS;
    case (it.op)
      OP_CHECK: begin
        if (it.tier == TIER_SILENT) begin
          v.outcome = OUT_SILENT;
        end else if (it.tier != TIER_URGENT && it.now < muted_until[c]) begin
          v.outcome = OUT_MUTED;
        end else if (it.tier != TIER_URGENT && hour_is_quiet(it.hour)) begin
          v.outcome = OUT_QUIET;
        end else begin
          last = fired_at[it.tier];
          need = min_gap[it.tier];
          // a stored time of zero means the tier never fired
          if (need != 0 && last != 0 && (it.now < last || it.now - last < need))
            v.outcome = OUT_RATE;
        end
      end
      OP_FIRE: begin
        if (it.tier != TIER_SILENT) fired_at[it.tier] = it.now;
      end
      OP_MUTE: begin
        muted_until[c] = expiry_after(it.now, it.mute_secs);
      end
      default: begin
        rejects_held[c] = (it.reject_in <= 0) ? '0 : it.reject_in[REJ_W-1:0];
        if (it.reject_in >= auto_mute_at) muted_until[c] = expiry_after(it.now, auto_mute_len);
      end
    endcase
    v.rejects    = rejects_held[c];
    v.last_fired = (it.tier == TIER_SILENT) ? '0 : fired_at[it.tier];
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    item_t    it;
    if (!rst_n) begin
      quiet_on      = 1'b1;
      quiet_from    = 5'd22;
      quiet_to      = 5'd7;
      min_gap[1]    = 31'd1800;
      min_gap[2]    = 31'd300;
      min_gap[3]    = 31'd0;
      auto_mute_at  = 16'sd3;
      auto_mute_len = 32'sd86400;
      foreach (fired_at[i]) fired_at[i] = '0;
      foreach (muted_until[i]) muted_until[i] = '0;
      foreach (rejects_held[i]) rejects_held[i] = '0;
      awaited_q.delete();
    end else begin
      if (out_valid) begin
        if (awaited_q.size() == 0) begin
          $error("result with nothing expected: outcome %0d reject_count %0d last_fired %0d",
                 out_outcome, out_reject_count, out_last_fired);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          done++;
          if (out_outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_outcome);
            fails++;
          end
          if (out_reject_count !== want.rejects) begin
            $error("reject_count: expected %0d, got %0d", want.rejects, out_reject_count);
            fails++;
          end
          if (out_last_fired !== want.last_fired) begin
            $error("last_fired: expected %0d, got %0d", want.last_fired, out_last_fired);
            fails++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:2]))
          REG_QUIET_EN:  quiet_on      = pwdata[0];
          REG_QUIET_ST:  quiet_from    = pwdata[4:0];
          REG_QUIET_END: quiet_to      = pwdata[4:0];
          REG_GAP_AMB:   min_gap[1]    = pwdata[GAP_W-1:0];
          REG_GAP_ACT:   min_gap[2]    = pwdata[GAP_W-1:0];
          REG_GAP_URG:   min_gap[3]    = pwdata[GAP_W-1:0];
          REG_REJ_LIMIT: auto_mute_at  = pwdata[15:0];
          REG_AUTO_MUTE: auto_mute_len = pwdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        it.op        = op_e'(in_op);
        it.tier      = tier_e'(in_tier);
        it.category  = in_category;
        it.now       = in_now_secs;
        it.hour      = in_local_hour;
        it.mute_secs = in_mute_secs;
        it.reject_in = in_reject_in;
        awaited_q.push_back(admit(it));
      end
    end
    awaiting = awaited_q.size();
  end

endmodule

FILE: tb/sv/tb_tiered_event_admission_gate_core.sv
// Testbench top for the tiered event admission gate: stimulus, register phases and verdict.
module tb_tiered_event_admission_gate_core;
  timeunit 1ns;
  timeprecision 1ps;
  import teag_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 96;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_op = '0;
  logic [1:0]          in_tier = '0;
  logic [5:0]          in_category = '0;
  logic [31:0]         in_now_secs = '0;
  logic [4:0]          in_local_hour = '0;
  logic signed [31:0]  in_mute_secs = '0;
  logic signed [15:0]  in_reject_in = '0;
  logic                out_valid;
  logic [2:0]          out_outcome;
  logic [14:0]         out_reject_count;
  logic [31:0]         out_last_fired;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  int          mismatches;
  int          awaiting;
  int          compared;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          settings_used = 1;
  logic [31:0] epoch = 32'd1_000_000;

  tiered_event_admission_gate_core dut (.*);
  teag_admission_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tiered_event_admission_gate_core verification failed");
      $finish;
    end
  end

  function automatic item_t mk(input op_e op, input tier_e tier, input int unsigned cat,
                               input logic [31:0] now, input int unsigned hour,
                               input int msecs, input int rin);
    item_t it;
    it.op        = op;
    it.tier      = tier;
    it.category  = 6'(cat);
    it.now       = now;
    it.hour      = 5'(hour);
    it.mute_secs = msecs;
    it.reject_in = 16'(rin);
    return it;
  endfunction

  // Mostly small time steps so that gaps and mutes bite, with jumps, wraps and steps back.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.op = pick < 45 ? OP_CHECK : pick < 65 ? OP_FIRE : pick < 82 ? OP_MUTE : OP_REJECT;
    it.tier = tier_e'($urandom_range(0, 3));
    it.category = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
    case ($urandom_range(0, 19))
      0:       epoch = $urandom;
      1:       epoch = epoch - $urandom_range(1, 500);
      2, 3, 4: epoch = epoch + $urandom_range(0, 5000);
      default: epoch = epoch + $urandom_range(0, 60);
    endcase
    it.now  = epoch;
    it.hour = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    if ($urandom_range(0, 7) == 0) it.mute_secs = $urandom;
    else if ($urandom_range(0, 3) == 0) it.mute_secs = -int'($urandom_range(0, 100));
    else it.mute_secs = $urandom_range(1, 600);
    if ($urandom_range(0, 7) == 0) it.reject_in = 16'($urandom);
    else it.reject_in = 16'(int'($urandom_range(0, 11)) - 3);
    return it;
  endfunction

  // Hold the item until accepted, then drop start and idle, if an idle count is given.
  task automatic send(input item_t it, input int unsigned idle);
    start         <= 1'b1;
    in_op         <= it.op;
    in_tier       <= it.tier;
    in_category   <= it.category;
    in_now_secs   <= it.now;
    in_local_hour <= it.hour;
    in_mute_secs  <= it.mute_secs;
    in_reject_in  <= it.reject_in;
    do @(posedge clk); while (busy);
    items_sent++;
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // psel stays high between back-to-back writes; the caller drops it after the last one.
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_phase(input int phase);
    logic [31:0] vals [NUM_REGS];
    case (phase)
      1: vals = '{32'd0, 32'd22, 32'd7, 32'd10, 32'd20, 32'd30, 32'd1, 32'd50};
      // equal bounds, gaps off, lowest limit, longest auto-mute
      2: vals = '{32'd1, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 32'h0000_8000, 32'h7FFF_FFFF};
      // plain window, widest gaps, highest limit, most negative auto-mute
      3: vals = '{32'd1, 32'd8, 32'd17, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0000_7FFF, 32'h8000_0000};
      // an hour above 23 as the window start
      4: vals = '{32'hFFFF_FFFF, 32'd31, 32'd0, 32'd1, 32'd1, 32'd1, 32'd0, 32'd1};
      default: begin
        vals[REG_QUIET_EN]  = ($urandom_range(0, 3) != 0) ? $urandom | 32'd1 : 32'd0;
        vals[REG_QUIET_ST]  = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 23);
        vals[REG_QUIET_END] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 23);
        for (int r = REG_GAP_AMB; r <= REG_GAP_URG; r++)
          vals[r] = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 200);
        vals[REG_REJ_LIMIT] = 32'(int'($urandom_range(0, 10)) - 3);
        vals[REG_AUTO_MUTE] = 32'(int'($urandom_range(0, 600)) - 100);
      end
    endcase
    for (int r = 0; r < NUM_REGS; r++) cfg_write(reg_idx_e'(r), vals[r]);
    psel    <= 1'b0;
    penable <= 1'b0;
    settings_used++;
  endtask

  // Runs under the reset register values: window 22..7, gaps 1800/300/0, limit 3.
  task automatic directed();
    item_t seq [$];
    seq.push_back(mk(OP_CHECK, TIER_SILENT, 0, 32'd0, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_AMBIENT, 0, 32'd1000, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_AMBIENT, 0, 32'd1000, 23, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_ACTIVE, 0, 32'd1000, 3, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_AMBIENT, 0, 32'd1000, 7, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_URGENT, 0, 32'd1000, 23, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_ACTIVE, 0, 32'd1000, 31, 0, 0));
    seq.push_back(mk(OP_FIRE, TIER_SILENT, 0, 32'd5000, 12, 0, 0));
    seq.push_back(mk(OP_FIRE, TIER_AMBIENT, 0, 32'd5000, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_AMBIENT, 0, 32'd5100, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_AMBIENT, 0, 32'd6800, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_AMBIENT, 0, 32'd4000, 12, 0, 0));
    seq.push_back(mk(OP_FIRE, TIER_ACTIVE, 1, 32'd10000, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_ACTIVE, 1, 32'd10299, 12, 0, 0));
    seq.push_back(mk(OP_FIRE, TIER_URGENT, 2, 32'hFFFF_FFFF, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_URGENT, 2, 32'd0, 12, 0, 0));
    seq.push_back(mk(OP_MUTE, TIER_AMBIENT, 63, 32'd100, 12, 1000, 0));
    seq.push_back(mk(OP_CHECK, TIER_AMBIENT, 63, 32'd500, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_URGENT, 63, 32'd500, 12, 0, 0));
    seq.push_back(mk(OP_CHECK, TIER_ACTIVE, 63, 32'd1100, 12, 0, 0));
    seq.push_back(mk(OP_MUTE, TIER_AMBIENT, 63, 32'd200, 12, 0, 0));
    seq.push_back(mk(OP_MUTE, TIER_ACTIVE, 5, 32'hFFFF_FFF0, 12, 32'h7FFF_FFFF, 0));
    seq.push_back(mk(OP_CHECK, TIER_ACTIVE, 5, 32'hFFFF_FFFE, 12, 0, 0));
    seq.push_back(mk(OP_MUTE, TIER_ACTIVE, 5, 32'd300, 12, 32'h8000_0000, 0));
    seq.push_back(mk(OP_REJECT, TIER_ACTIVE, 0, 32'd20000, 12, 0, 32767));
    seq.push_back(mk(OP_CHECK, TIER_ACTIVE, 0, 32'd20001, 12, 0, 0));
    seq.push_back(mk(OP_REJECT, TIER_URGENT, 0, 32'd20002, 12, 0, -32768));
    seq.push_back(mk(OP_REJECT, TIER_AMBIENT, 1, 32'd20003, 12, 0, 2));
    seq.push_back(mk(OP_REJECT, TIER_AMBIENT, 1, 32'd20004, 12, 0, 0));
    foreach (seq[i]) send(seq[i], ($urandom_range(0, 2) == 0) ? $urandom_range(1, 14) : 0);
  endtask

  initial begin
    bit steady;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed();
    for (int phase = 1; phase <= PHASES; phase++) begin
      drain();
      program_phase(phase);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // redraw the idling style every 32 items: some stretches run back to back
        if (n % 32 == 0) steady = ($urandom_range(0, 3) == 0);
        send(random_item(), steady ? 0 : $urandom_range(0, 14));
      end
    end
    drain();
    $display("Covered %0d items (directed edge cases, then random) over %0d register settings.",
             items_sent, settings_used);
    $display("Compared %0d results, %0d mismatching fields.", compared, mismatches);
    if (mismatches == 0) begin
      $display("tiered_event_admission_gate_core verification clean");
    end else begin
      $display("tiered_event_admission_gate_core verification failed");
    end
    $finish;
  end

endmodule

FILE: tiered_event_admission_gate_core.f
sv/teag_pkg.sv
sv/teag_ram.sv
sv/teag_cfg_regs.sv
sv/teag_eval.sv
sv/tiered_event_admission_gate_core.sv
tb/sv/teag_admission_checker.sv
tb/sv/tb_tiered_event_admission_gate_core.sv
